// File: src/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the CRC16 packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0]  START_BYTE_RST    = 8'h5A;
   localparam logic [8:0]  MAX_LENGTH_RST    = 9'd256;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

   // payload limit
   localparam int MAX_DATA_DEF = 256;

   // CRC16-CCITT
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // result kinds and status codes
   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_BAD_START = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_CRC_BAD   = 3'd4;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [8:0]  max_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [7:0]  command;
      logic [15:0] frame_length;
      logic [2:0]  status;
   } rsp_type;

endpackage

// File: src/cpd_if.sv
// ----------------------------------------------------------------------------
// cpd_req_if / cpd_rsp_if
// Valid/ready channels of the deframer: received words in, results out.
// ----------------------------------------------------------------------------
interface cpd_req_if;
   logic       valid;
   logic       ready;
   logic       is_tick;
   logic [7:0] rx_byte;

   modport source (output valid, output is_tick, output rx_byte, input ready);
   modport sink   (input valid, input is_tick, input rx_byte, output ready);
endinterface

interface cpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  data_byte;
   logic [7:0]  data_index;
   logic [7:0]  command;
   logic [15:0] frame_length;
   logic [2:0]  status;

   modport source (output valid, output out_kind, output data_byte, output data_index,
                   output command, output frame_length, output status, input ready);
   modport sink   (input valid, input out_kind, input data_byte, input data_index,
                   input command, input frame_length, input status, output ready);
endinterface

// File: src/crc16_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_core
// Frame parser with CRC16-CCITT check, data pass-through and tick timeout.
// ----------------------------------------------------------------------------
// Takes one word per clock unless a result stalls: a received byte or a time
// tick. Each word is parsed in the cycle it is accepted and its result, if
// any, appears in the output register on the next cycle. req.ready is high
// whenever the output register is empty or is being drained in the same
// cycle; a stalled result holds input only while rsp.ready is low. Data
// bytes come out as they arrive; the status word that closes the frame
// tells the consumer whether to keep them.
module crc16_packet_deframer_core
   import cpd_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cpd_req_if.sink               req,
   cpd_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   logic    accept;
   logic    res_valid;
   rsp_type res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= START_BYTE_RST;
         cfg_ff.max_length    <= MAX_LENGTH_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:    cfg_ff.start_byte    <= csr_wdata[7:0];
            CSR_MAX_LENGTH:    cfg_ff.max_length    <= csr_wdata[8:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req.ready = !out_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   cpd_parser #(
      .MAX_DATA (MAX_DATA)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .is_tick   (req.is_tick),
      .rx_byte   (req.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: load a new result, else drop the taken one
   assign out_valid_in = (accept && res_valid) ? 1'b1
                       : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_kind     = out_ff.out_kind;
   assign rsp.data_byte    = out_ff.data_byte;
   assign rsp.data_index   = out_ff.data_index;
   assign rsp.command      = out_ff.command;
   assign rsp.frame_length = out_ff.frame_length;
   assign rsp.status       = out_ff.status;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req.ready)
      else $error("input stalled with empty output register");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.out_kind == KIND_STATUS)
         |-> (out_ff.data_byte == 8'd0) && (out_ff.data_index == 8'd0))
      else $error("status word carries data fields");

   a_data_status_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.out_kind == KIND_DATA) |-> (out_ff.status == ST_OK))
      else $error("data word carries a status code");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid |=> out_valid_ff)
      else $error("result lost on its way to the output register");

endmodule

// File: src/cpd_crc.sv
// ----------------------------------------------------------------------------
// cpd_crc
// One byte of CRC16-CCITT (MSB first), unrolled over eight bit steps.
// ----------------------------------------------------------------------------
module cpd_crc
   import cpd_pkg::*;
(
   input  logic [15:0] crc_in,
   input  logic [7:0]  data,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_out = acc;
   end

endmodule

// File: src/cpd_parser.sv
// ----------------------------------------------------------------------------
// cpd_parser
// Frame state machine: tracks phase, CRC, header fields and idle ticks, and
// forms at most one result per accepted word.
// ----------------------------------------------------------------------------
module cpd_parser
   import cpd_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       accept,
   input  logic       is_tick,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output rsp_type    res
);

   localparam int CNT_BITS = $clog2(MAX_DATA + 1);
   localparam int CNT_W    = (CNT_BITS > 8) ? CNT_BITS : 8;
   localparam logic [16:0] MAX_DATA_L = 17'(MAX_DATA);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_CMD    = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;
   localparam logic [2:0] PH_CRC_HI = 3'd6;

   logic [2:0]       phase_ff, phase_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [15:0]      idle_ff, idle_in;

   logic [15:0]      crc_next;
   logic [15:0]      idle_inc;
   logic [15:0]      len_full;
   logic [16:0]      limit;
   logic [CNT_W-1:0] cnt_inc;
   logic             in_frame;

   cpd_crc u_crc (
      .crc_in  (crc_ff),
      .data    (rx_byte),
      .crc_out (crc_next)
   );

   assign in_frame = (phase_ff >= PH_CMD) && (phase_ff <= PH_CRC_HI);
   assign idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign len_full = {rx_byte, len_ff[7:0]};
   assign limit    = ({8'd0, cfg.max_length} < MAX_DATA_L) ? {8'd0, cfg.max_length}
                                                             : MAX_DATA_L;
   assign cnt_inc  = cnt_ff + CNT_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      crc_lo_in = crc_lo_ff;
      idle_in   = idle_ff;
      res_valid = 1'b0;
      res       = '0;
      res.out_kind     = KIND_STATUS;
      res.command      = in_frame ? cmd_ff : 8'd0;
      res.frame_length = in_frame ? len_ff : 16'd0;

      if (is_tick) begin
         idle_in = idle_inc;
         if (idle_inc >= cfg.timeout_ticks) begin
            idle_in    = '0;
            res_valid  = 1'b1;
            res.status = ST_TIMEOUT;
            phase_in   = PH_IDLE;
            crc_in     = CRC_INIT;
         end
      end else begin
         idle_in = '0;
         case (phase_ff)
            PH_CMD: begin
               cmd_in   = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in   = {8'd0, rx_byte};
               crc_in   = crc_next;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in = len_full;
               crc_in = crc_next;
               if ({1'b0, len_full} > limit) begin
                  // end the frame at once, header echoed
                  res_valid        = 1'b1;
                  res.status       = ST_TOO_LONG;
                  res.frame_length = len_full;
                  phase_in         = PH_IDLE;
                  crc_in           = CRC_INIT;
               end else begin
                  cnt_in   = '0;
                  phase_in = (len_full == 16'd0) ? PH_CRC_LO : PH_DATA;
               end
            end
            PH_DATA: begin
               res_valid      = 1'b1;
               res.out_kind   = KIND_DATA;
               res.data_byte  = rx_byte;
               res.data_index = cnt_ff[7:0];
               crc_in         = crc_next;
               cnt_in         = cnt_inc;
               if (16'(cnt_inc) >= len_ff) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = rx_byte;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               res_valid  = 1'b1;
               res.status = (crc_ff == {rx_byte, crc_lo_ff}) ? ST_OK : ST_CRC_BAD;
               phase_in   = PH_IDLE;
               crc_in     = CRC_INIT;
            end
            default: begin
               if (rx_byte == cfg.start_byte) begin
                  phase_in = PH_CMD;
                  crc_in   = CRC_INIT;
                  cmd_in   = '0;
                  len_in   = '0;
                  cnt_in   = '0;
               end else begin
                  res_valid  = 1'b1;
                  res.status = ST_BAD_START;
                  phase_in   = PH_IDLE;
                  crc_in     = CRC_INIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         crc_ff    <= CRC_INIT;
         cmd_ff    <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         crc_lo_ff <= '0;
         idle_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         crc_lo_ff <= crc_lo_in;
         idle_ff   <= idle_in;
      end
   end

endmodule

// File: dv/crc16_packet_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer_core_tb
// Self-checking bench for the CRC16 frame deframer.
// ----------------------------------------------------------------------------
// A directed table walks the status paths by hand: bad start, empty payload,
// CRC mismatch, oversize length, timeouts and register corner values. Random
// phases follow, each with its own register setting, sender burst profile and
// receiver stall pattern. They send mostly well-formed frames with random
// content, mixed with stray bytes, tick runs, corrupt CRCs and abandoned
// frames. A bit-accurate parser model predicts every result that the table
// does not pin, and a scoreboard checks the results in order.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_core_tb
   import cpd_pkg::*;
;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int ITEM_TARGET    = 1700;
   localparam int N_PHASES       = 12;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   // index with no register behind it; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      PH_WAIT_START, PH_CMD, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CRC_LO, PH_CRC_HI
   } deframe_phase_type;

   typedef enum logic [2:0] {
      OP_BYTE, OP_TICK, OP_CRC_LO, OP_CRC_HI, OP_CSR
   } word_op_type;

   typedef enum logic [1:0] {
      SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC, SINK_LONG
   } sink_mode_type;

   typedef struct packed {
      word_op_type          op;
      logic [CSR_IDX_W-1:0] idx;
      logic [15:0]          val;   // byte, CRC xor mask, or register data
      logic                 pin;
      rsp_type              exp;
   } stim_row_type;

   typedef struct packed {
      word_op_type op;
      logic [7:0]  val;
   } word_type;

   localparam rsp_type NO_RSP = '0;

   localparam stim_row_type DIRECTED [26] = '{
      '{OP_BYTE,   '0, 16'h0000, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'h00, 16'h0000, ST_BAD_START}},
      // empty payload goes straight to the CRC bytes
      '{OP_BYTE,   '0, 16'h005A, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0001, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_CRC_LO, '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_CRC_HI, '0, 16'h0000, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'h01, 16'h0000, ST_OK}},
      // two data bytes, then a corrupt CRC high byte
      '{OP_BYTE,   '0, 16'h005A, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h00FF, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0002, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h00FF, 1'b0, NO_RSP},
      '{OP_CRC_LO, '0, 16'h0000, 1'b0, NO_RSP},
      '{OP_CRC_HI, '0, 16'h00FF, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'hFF, 16'h0002, ST_CRC_BAD}},
      '{OP_BYTE,   '0, 16'h005A, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0033, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h00FF, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h00FF, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'h33, 16'hFFFF, ST_TOO_LONG}},
      // zero timeout: every tick times out, idle or inside a frame
      '{OP_CSR, CSR_TIMEOUT_TICKS, 16'h0000, 1'b0, NO_RSP},
      '{OP_TICK,   '0, 16'h0000, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'h00, 16'h0000, ST_TIMEOUT}},
      '{OP_BYTE,   '0, 16'h005A, 1'b0, NO_RSP},
      '{OP_BYTE,   '0, 16'h0044, 1'b0, NO_RSP},
      '{OP_TICK,   '0, 16'h0000, 1'b1,
        '{KIND_STATUS, 8'h00, 8'h00, 8'h44, 16'h0000, ST_TIMEOUT}},
      // upper data bits must be dropped: start byte 0x00, max length 0
      '{OP_CSR, CSR_START_BYTE, 16'hFF00, 1'b0, NO_RSP},
      '{OP_CSR, CSR_MAX_LENGTH, 16'hFE00, 1'b0, NO_RSP}
   };

   localparam word_type ZERO_LIMIT_FRAME [4] = '{
      '{OP_BYTE, 8'h00}, '{OP_BYTE, 8'h07}, '{OP_BYTE, 8'h01}, '{OP_BYTE, 8'h00}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cpd_req_if req_ch ();
   cpd_rsp_if rsp_ch ();

   crc16_packet_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // parser model state
   cfg_type           cfg;
   deframe_phase_type ph;
   logic [15:0]       crc_acc;
   logic [7:0]        cur_cmd;
   logic [15:0]       cur_len;
   logic [8:0]        data_cnt;
   logic [7:0]        crc_lo_rx;
   logic [15:0]       tick_cnt;

   rsp_type           pending_results [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                bytes_sent = 0;

   // sender and receiver profile
   logic              req_pinned;
   rsp_type           req_pin_rsp;
   int                burst_left = 0;
   int                gap_max = 3;
   sink_mode_type     sink_mode = SINK_RANDOM;
   int                stall_cnt = 0;

   function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic logic [8:0] length_limit();
      return (cfg.max_length < MAX_DATA_DEF) ? cfg.max_length : 9'(MAX_DATA_DEF);
   endfunction

   function automatic rsp_type close_frame(logic [2:0] st, logic in_frame);
      rsp_type r;
      r = '0;
      r.out_kind     = KIND_STATUS;
      r.command      = in_frame ? cur_cmd : 8'h00;
      r.frame_length = in_frame ? cur_len : 16'h0000;
      r.status       = st;
      ph      = PH_WAIT_START;
      crc_acc = CRC_INIT;
      return r;
   endfunction

   function automatic logic deframe_word(logic is_tick, logic [7:0] b, output rsp_type r);
      logic in_frame;
      r = '0;
      in_frame = (ph != PH_WAIT_START);
      if (is_tick) begin
         if (tick_cnt != 16'hFFFF)
            tick_cnt++;
         // a zero timeout fires on every tick, same as one
         if (tick_cnt >= cfg.timeout_ticks) begin
            tick_cnt = '0;
            r = close_frame(ST_TIMEOUT, in_frame);
            return 1'b1;
         end
         return 1'b0;
      end
      tick_cnt = '0;
      case (ph)
         PH_CMD: begin
            cur_cmd = b;
            crc_acc = crc16_ccitt_byte(crc_acc, b);
            ph = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            cur_len = {8'h00, b};
            crc_acc = crc16_ccitt_byte(crc_acc, b);
            ph = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            cur_len[15:8] = b;
            crc_acc = crc16_ccitt_byte(crc_acc, b);
            if (cur_len > length_limit()) begin
               r = close_frame(ST_TOO_LONG, 1'b1);
               return 1'b1;
            end
            data_cnt = '0;
            if (cur_len == 16'h0000)
               ph = PH_CRC_LO;
            else
               ph = PH_DATA;
         end
         PH_DATA: begin
            r.out_kind     = KIND_DATA;
            r.data_byte    = b;
            r.data_index   = data_cnt[7:0];
            r.command      = cur_cmd;
            r.frame_length = cur_len;
            crc_acc = crc16_ccitt_byte(crc_acc, b);
            data_cnt++;
            if ({7'b0, data_cnt} >= cur_len)
               ph = PH_CRC_LO;
            return 1'b1;
         end
         PH_CRC_LO: begin
            crc_lo_rx = b;
            ph = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            r = close_frame((crc_acc == {b, crc_lo_rx}) ? ST_OK : ST_CRC_BAD, 1'b1);
            return 1'b1;
         end
         default: begin
            if (b == cfg.start_byte) begin
               ph       = PH_CMD;
               crc_acc  = CRC_INIT;
               cur_cmd  = '0;
               cur_len  = '0;
               data_cnt = '0;
               return 1'b0;
            end
            r = close_frame(ST_BAD_START, 1'b0);
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_START_BYTE:    cfg.start_byte    = data[7:0];
         CSR_MAX_LENGTH:    cfg.max_length    = data[8:0];
         CSR_TIMEOUT_TICKS: cfg.timeout_ticks = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic string describe(rsp_type r);
      return $sformatf("kind=%0d byte=%02h index=%0d cmd=%02h len=%04h status=%0d",
                       r.out_kind, r.data_byte, r.data_index, r.command,
                       r.frame_length, r.status);
   endfunction

   // receiver: stall on a pattern chosen per phase
   always @(negedge clock) begin
      stall_cnt++;
      case (sink_mode)
         SINK_ALWAYS:   rsp_ch.ready <= 1'b1;
         SINK_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 99) < 70);
         SINK_PERIODIC: rsp_ch.ready <= ((stall_cnt % 5) != 0);
         default:       rsp_ch.ready <= ((stall_cnt % 24) >= 9);
      endcase
   end

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type got;
      logic    produced;
      logic    took_word;
      logic    gave_result;
      if (reset) begin
         cfg.start_byte    = START_BYTE_RST;
         cfg.max_length    = MAX_LENGTH_RST;
         cfg.timeout_ticks = TIMEOUT_TICKS_RST;
         ph        = PH_WAIT_START;
         crc_acc   = CRC_INIT;
         cur_cmd   = '0;
         cur_len   = '0;
         data_cnt  = '0;
         crc_lo_rx = '0;
         tick_cnt  = '0;
         quiet_cycles = 0;
      end else begin
         took_word   = req_ch.valid && req_ch.ready;
         gave_result = rsp_ch.valid && rsp_ch.ready;
         if (csr_we)
            apply_register(csr_index, csr_wdata);
         // queue the prediction before checking any result taken at the same edge
         if (took_word) begin
            produced = deframe_word(req_ch.is_tick, req_ch.rx_byte, predicted);
            if (req_pinned)
               pending_results.push_back(req_pin_rsp);
            else if (produced)
               pending_results.push_back(predicted);
         end
         if (gave_result) begin
            got = '{rsp_ch.out_kind, rsp_ch.data_byte, rsp_ch.data_index,
                    rsp_ch.command, rsp_ch.frame_length, rsp_ch.status};
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %s",
                        $time, describe(got));
               mismatch_count++;
            end else if (got !== pending_results[0]) begin
               $display("%0t: result mismatch: expected %s, actual %s",
                        $time, describe(pending_results[0]), describe(got));
               mismatch_count++;
               void'(pending_results.pop_front());
            end else begin
               void'(pending_results.pop_front());
            end
         end
         if (took_word || gave_result)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("crc16_packet_deframer_core regression: fail");
            $finish;
         end
      end
   end

   task automatic send_word(word_op_type op, logic [7:0] val, logic pin, rsp_type pin_rsp);
      int         gap;
      logic [7:0] b;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      // CRC words are resolved here, once every earlier word has been parsed
      case (op)
         OP_CRC_LO: b = crc_acc[7:0] ^ val;
         OP_CRC_HI: b = crc_acc[15:8] ^ val;
         OP_TICK:   b = 8'($urandom_range(0, 255));
         default:   b = val;
      endcase
      req_ch.valid   <= 1'b1;
      req_ch.is_tick <= (op == OP_TICK);
      req_ch.rx_byte <= b;
      req_pinned     <= pin;
      req_pin_rsp    <= pin_rsp;
      bytes_sent++;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_word(OP_TICK, 8'h00, 1'b0, NO_RSP);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // one frame with random content, sometimes broken on purpose
   task automatic send_frame();
      word_type   seq [$];
      int         r;
      int         len;
      int         cut;
      int         tmo;
      logic [8:0] lim;
      logic [7:0] mask_lo;
      logic [7:0] mask_hi;
      lim = length_limit();
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, NO_RSP);
      if ($urandom_range(0, 9) == 0)
         send_ticks($urandom_range(1, 4));
      r = $urandom_range(0, 99);
      if (r < 3)
         len = lim;
      else if (r < 13)
         len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535);
      else
         len = $urandom_range(0, (lim < 8) ? lim : 8);
      mask_lo = '0;
      mask_hi = '0;
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1))
            mask_lo = 8'(1 << $urandom_range(0, 7));
         else
            mask_hi = 8'(1 << $urandom_range(0, 7));
      end
      seq.push_back('{OP_BYTE, cfg.start_byte});
      seq.push_back('{OP_BYTE, 8'($urandom_range(0, 255))});
      seq.push_back('{OP_BYTE, len[7:0]});
      seq.push_back('{OP_BYTE, len[15:8]});
      if (len <= lim) begin
         repeat (len) seq.push_back('{OP_BYTE, 8'($urandom_range(0, 255))});
         seq.push_back('{OP_CRC_LO, mask_lo});
         seq.push_back('{OP_CRC_HI, mask_hi});
      end
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, seq.size() - 1) : -1;
      foreach (seq[i]) begin
         if (i == cut) begin
            // abandon the frame and, unless the timeout exceeds 300 ticks, let it clear the parser
            tmo = (cfg.timeout_ticks == 0) ? 1 : cfg.timeout_ticks;
            if (tmo <= 300)
               send_ticks(tmo);
            return;
         end
         if ($urandom_range(0, 11) == 0)
            send_ticks($urandom_range(1, 3));
         send_word(seq[i].op, seq[i].val, 1'b0, NO_RSP);
      end
   endtask

   initial begin : stimulus
      logic [7:0]  sb;
      logic [8:0]  ml;
      logic [15:0] tmo;
      int          phase_goal;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.is_tick = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      req_pinned     = 1'b0;
      req_pin_rsp    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].op == OP_CSR) begin
            wait_idle();
            write_reg(DIRECTED[i].idx, DIRECTED[i].val);
         end else begin
            send_word(DIRECTED[i].op, DIRECTED[i].val[7:0], DIRECTED[i].pin,
                      DIRECTED[i].exp);
         end
      end
      // max length 0 rejects a one-byte payload
      foreach (ZERO_LIMIT_FRAME[i])
         send_word(ZERO_LIMIT_FRAME[i].op, ZERO_LIMIT_FRAME[i].val,
                   i == 3, '{KIND_STATUS, 8'h00, 8'h00, 8'h07, 16'h0001, ST_TOO_LONG});
      wait_idle();
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));

      bytes_sent = 0;
      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         case (p % 4)
            0:       sb = 8'h00;
            1:       sb = 8'hFF;
            default: sb = 8'($urandom_range(0, 255));
         endcase
         case (p % 5)
            0:       ml = 9'd256;
            1:       ml = 9'd511;
            2:       ml = 9'd0;
            3:       ml = 9'd1;
            default: ml = 9'($urandom_range(0, 511));
         endcase
         case (p % 6)
            0:       tmo = 16'd100;
            1:       tmo = 16'hFFFF;
            2:       tmo = 16'd0;
            3:       tmo = 16'd1;
            4:       tmo = 16'd3;
            default: tmo = 16'($urandom_range(2, 40));
         endcase
         write_reg(CSR_START_BYTE, {8'($urandom_range(0, 255)), sb});
         write_reg(CSR_MAX_LENGTH, {7'($urandom_range(0, 127)), ml});
         write_reg(CSR_TIMEOUT_TICKS, tmo);
         if (p % 3 == 0)
            write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
         sink_mode  = sink_mode_type'(p % 4);
         gap_max    = (p % 3 == 0) ? 0 : $urandom_range(1, 12);
         phase_goal = (p + 1) * ITEM_TARGET / N_PHASES;
         while (bytes_sent < phase_goal)
            send_frame();
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("crc16_packet_deframer_core regression: pass");
      else
         $display("crc16_packet_deframer_core regression: fail");
      $finish;
   end

endmodule

// File: crc16_packet_deframer_core.f
src/cpd_pkg.sv
src/cpd_if.sv
src/cpd_crc.sv
src/cpd_parser.sv
src/crc16_packet_deframer_core.sv
dv/crc16_packet_deframer_core_tb.sv
